### rtl/balance_servo_pid_three_mode_assert.svh
// Assertion macros used by the checker module.
`ifndef BALANCE_SERVO_PID_THREE_MODE_ASSERT_SVH
`define BALANCE_SERVO_PID_THREE_MODE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsp: assertion failed");

// Next-cycle implication.
`define BSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsp: assertion failed");

`endif

### rtl/bsp_pkg.sv
`default_nettype none
package bsp_pkg;

    localparam int INT_CLAMP_DEF = 3200;
    localparam int MID_DUTY_DEF  = 750;

    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int ANG_W     = 16;
    localparam int ERR_W     = ANG_W + 1;
    localparam int INT_W     = 16;
    localparam int RERR_W    = 28;
    localparam int ACC_W     = 46;
    localparam int LIM_W     = 12;
    localparam int OFF_W     = 13;
    localparam int DUTY_W    = 14;
    localparam int SUM_W     = 16;
    localparam int BIT_CNT_W = $clog2(GAIN_W);

    localparam int DUTY_MAX = (1 << DUTY_W) - 1;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [INT_W-1:0]  t_int;
    typedef logic signed [RERR_W-1:0] t_rerr;
    typedef logic signed [OFF_W-1:0]  t_off;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [GAIN_W-1:0]        t_gain;

    // control_mode codes; the unused code runs as simple
    localparam logic [1:0] MODE_SIMPLE  = 2'd0;
    localparam logic [1:0] MODE_CASCADE = 2'd1;
    localparam logic [1:0] MODE_LOWSPD  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REVERSED = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUTER_KP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTER_KI = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_KD  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INNER_KP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INNER_KI = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OUT_LIM  = 3'd7;

    localparam logic [1:0]        RST_MODE     = MODE_SIMPLE;
    localparam logic              RST_REVERSED = 1'b1;
    localparam t_gain             RST_OUTER_KP = 16'd5120;
    localparam t_gain             RST_OUTER_KI = 16'd64;
    localparam t_gain             RST_GYRO_KD  = 16'd13;
    localparam t_gain             RST_INNER_KP = 16'd256;
    localparam t_gain             RST_INNER_KI = 16'd0;
    localparam logic [LIM_W-1:0]  RST_OUT_LIM  = 12'd250;

endpackage
`default_nettype wire

### rtl/bsp_ifs.sv
`default_nettype none
interface bsp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  enable;
    logic signed [bsp_pkg::ANG_W-1:0]      target_angle;
    logic signed [bsp_pkg::ANG_W-1:0]      roll_angle;
    logic signed [bsp_pkg::ANG_W-1:0]      gyro_rate;

    modport source (output valid, output enable, output target_angle,
                    output roll_angle, output gyro_rate, input ready);
    modport sink   (input valid, input enable, input target_angle,
                    input roll_angle, input gyro_rate, output ready);
endinterface

interface bsp_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [bsp_pkg::DUTY_W-1:0]            servo_duty;
    logic signed [bsp_pkg::OFF_W-1:0]      steer_offset;

    modport source (output valid, output servo_duty, output steer_offset, input ready);
    modport sink   (input valid, input servo_duty, input steer_offset, output ready);
endinterface
`default_nettype wire

### rtl/balance_servo_pid_three_mode.sv
`default_nettype none
// Balance servo controller, one control tick per input item. The angle error
// drives a simple PID (P and clamped I on the angle, D on the gyro rate), a
// cascade of an outer angle PI and an inner rate PI, or a low-speed PI. All
// products go through one bit-serial shift-add multiplier that consumes one
// gain bit per cycle, so the item time follows from the product count: three
// products in simple mode, two in low-speed mode and four in cascade mode. A
// disabled item clears both integrals in its accept cycle and gives no result.
// The result sits in an output register, so the next item is taken while it
// waits. The user must write registers through the plain write port only while
// the block is idle; the block itself does not enforce this.
module balance_servo_pid_three_mode #(
    parameter int INT_CLAMP = bsp_pkg::INT_CLAMP_DEF,
    parameter int MID_DUTY  = bsp_pkg::MID_DUTY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bsp_in_if.sink                              i_in,
    bsp_out_if.source                           o_res,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bsp_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bsp_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RATE = 3'd2;
    localparam logic [2:0] ST_RINT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int AI_W = bsp_pkg::INT_W + 2;
    localparam int RI_W = bsp_pkg::RERR_W + 1;

    localparam logic signed [AI_W-1:0] ILIM_A = AI_W'(INT_CLAMP);
    localparam logic signed [RI_W-1:0] ILIM_R = RI_W'(INT_CLAMP);
    localparam bsp_pkg::t_sum          MID_S  = bsp_pkg::SUM_W'(MID_DUTY);
    localparam bsp_pkg::t_sum          DMAX_S = bsp_pkg::SUM_W'(bsp_pkg::DUTY_MAX);
    localparam bsp_pkg::t_acc          RND8   = bsp_pkg::t_acc'(1) <<< 7;
    localparam bsp_pkg::t_acc          RND12  = bsp_pkg::t_acc'(1) <<< 11;

    // configuration
    logic [1:0]                    r_mode;
    logic                          r_rev;
    bsp_pkg::t_gain                r_kp, r_ki, r_kd, r_ikp, r_iki;
    logic [bsp_pkg::LIM_W-1:0]     r_lim;

    // state and datapath
    logic [2:0]                    r_state;
    logic [1:0]                    r_step;
    logic [bsp_pkg::BIT_CNT_W-1:0] r_bit;
    bsp_pkg::t_int                 r_aint, r_rint;
    logic signed [bsp_pkg::ANG_W-1:0] r_gyro;
    bsp_pkg::t_rerr                r_rerr;
    bsp_pkg::t_acc                 r_mcand, r_acc;
    bsp_pkg::t_gain                r_mplier;
    bsp_pkg::t_off                 r_off;
    logic                          r_ov;
    logic [bsp_pkg::DUTY_W-1:0]    r_duty;
    bsp_pkg::t_off                 r_soff;

    logic                          l_accept, l_casc, l_low, l_out_wr;
    logic [1:0]                    l_step, l_last;
    bsp_pkg::t_err                 l_in_err;
    logic signed [AI_W-1:0]        l_aint_sum;
    bsp_pkg::t_int                 l_aint_new;
    logic signed [RI_W-1:0]        l_rint_sum;
    bsp_pkg::t_int                 l_rint_new;
    bsp_pkg::t_acc                 l_ld_mcand, l_tgt, l_fin, l_lim, l_clip;
    bsp_pkg::t_gain                l_ld_gain;
    bsp_pkg::t_rerr                l_rerr;
    bsp_pkg::t_off                 l_off;
    bsp_pkg::t_sum                 l_dsum;
    logic [bsp_pkg::DUTY_W-1:0]    l_duty;

    assign i_in.ready = (r_state == ST_IDLE);
    assign l_accept   = i_in.valid && (r_state == ST_IDLE);
    assign l_casc     = (r_mode == bsp_pkg::MODE_CASCADE);
    assign l_low      = (r_mode == bsp_pkg::MODE_LOWSPD);
    assign l_last     = l_casc ? 2'd3 : (l_low ? 2'd1 : 2'd2);

    assign l_in_err   = bsp_pkg::t_err'(i_in.target_angle) - bsp_pkg::t_err'(i_in.roll_angle);
    assign l_aint_sum = AI_W'(r_aint) + AI_W'(l_in_err);
    assign l_rint_sum = RI_W'(r_rint) + RI_W'(r_rerr);

    always_comb begin
        if (l_aint_sum > ILIM_A) begin
            l_aint_new = bsp_pkg::t_int'(ILIM_A);
        end else if (l_aint_sum < -ILIM_A) begin
            l_aint_new = bsp_pkg::t_int'(-ILIM_A);
        end else begin
            l_aint_new = bsp_pkg::t_int'(l_aint_sum);
        end
        if (l_rint_sum > ILIM_R) begin
            l_rint_new = bsp_pkg::t_int'(ILIM_R);
        end else if (l_rint_sum < -ILIM_R) begin
            l_rint_new = bsp_pkg::t_int'(-ILIM_R);
        end else begin
            l_rint_new = bsp_pkg::t_int'(l_rint_sum);
        end
    end

    // operand pair for the product about to start
    assign l_step = (r_state == ST_IDLE) ? 2'd0 : r_step + 2'd1;

    always_comb begin
        case (l_step)
            2'd0: begin
                l_ld_mcand = bsp_pkg::t_acc'(l_in_err);
                l_ld_gain  = r_kp;
            end
            2'd1: begin
                l_ld_mcand = bsp_pkg::t_acc'(r_aint);
                l_ld_gain  = r_ki;
            end
            2'd2: begin
                l_ld_mcand = l_casc ? bsp_pkg::t_acc'(r_rerr) : bsp_pkg::t_acc'(r_gyro);
                l_ld_gain  = l_casc ? r_ikp : r_kd;
            end
            2'd3: begin
                l_ld_mcand = bsp_pkg::t_acc'(r_rint);
                l_ld_gain  = r_iki;
            end
            default: begin
                l_ld_mcand = '0;
                l_ld_gain  = '0;
            end
        endcase
    end

    // cascade target rate, floor-shift after half-LSB bias
    assign l_tgt  = (r_acc + RND8) >>> 8;
    assign l_rerr = bsp_pkg::t_rerr'(l_tgt) - bsp_pkg::t_rerr'(r_gyro);

    assign l_fin  = (r_acc + RND12) >>> 12;
    assign l_lim  = bsp_pkg::t_acc'(r_lim);

    always_comb begin
        if (l_fin > l_lim) begin
            l_clip = l_lim;
        end else if (l_fin < -l_lim) begin
            l_clip = -l_lim;
        end else begin
            l_clip = l_fin;
        end
        l_off = r_rev ? -bsp_pkg::t_off'(l_clip) : bsp_pkg::t_off'(l_clip);
    end

    assign l_dsum = MID_S + bsp_pkg::t_sum'(r_off);

    always_comb begin
        if (l_dsum < 0) begin
            l_duty = '0;
        end else if (l_dsum > DMAX_S) begin
            l_duty = bsp_pkg::DUTY_W'(DMAX_S);
        end else begin
            l_duty = bsp_pkg::DUTY_W'(l_dsum);
        end
    end

    assign l_out_wr = (r_state == ST_OUT) && (!r_ov || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bsp_pkg::RST_MODE;
            r_rev   <= bsp_pkg::RST_REVERSED;
            r_kp    <= bsp_pkg::RST_OUTER_KP;
            r_ki    <= bsp_pkg::RST_OUTER_KI;
            r_kd    <= bsp_pkg::RST_GYRO_KD;
            r_ikp   <= bsp_pkg::RST_INNER_KP;
            r_iki   <= bsp_pkg::RST_INNER_KI;
            r_lim   <= bsp_pkg::RST_OUT_LIM;
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
            r_aint  <= '0;
            r_rint  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    bsp_pkg::REG_MODE:     r_mode <= i_cfg_data[1:0];
                    bsp_pkg::REG_REVERSED: r_rev  <= i_cfg_data[0];
                    bsp_pkg::REG_OUTER_KP: r_kp   <= i_cfg_data;
                    bsp_pkg::REG_OUTER_KI: r_ki   <= i_cfg_data;
                    bsp_pkg::REG_GYRO_KD:  r_kd   <= i_cfg_data;
                    bsp_pkg::REG_INNER_KP: r_ikp  <= i_cfg_data;
                    bsp_pkg::REG_INNER_KI: r_iki  <= i_cfg_data;
                    bsp_pkg::REG_OUT_LIM:  r_lim  <= i_cfg_data[bsp_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end

            if (l_out_wr) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (l_accept) begin
                        if (i_in.enable) begin
                            r_aint  <= l_aint_new;
                            if (!l_casc) begin
                                r_rint <= '0;
                            end
                            r_step  <= '0;
                            r_bit   <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_aint <= '0;
                            r_rint <= '0;
                        end
                    end
                end
                ST_MUL: begin
                    r_bit <= r_bit + bsp_pkg::BIT_CNT_W'(1);
                    if (r_bit == bsp_pkg::BIT_CNT_W'(bsp_pkg::GAIN_W - 1)) begin
                        if (r_step == l_last) begin
                            r_state <= ST_FIN;
                        end else if (l_casc && (r_step == 2'd1)) begin
                            r_state <= ST_RATE;
                        end else begin
                            r_step <= l_step;
                        end
                    end
                end
                ST_RATE: begin
                    r_state <= ST_RINT;
                end
                ST_RINT: begin
                    r_rint  <= l_rint_new;
                    r_step  <= l_step;
                    r_bit   <= '0;
                    r_state <= ST_MUL;
                end
                ST_FIN: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (l_out_wr) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_gyro   <= i_in.gyro_rate;
                r_acc    <= '0;
                r_mcand  <= l_ld_mcand;
                r_mplier <= l_ld_gain;
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                if (r_bit == bsp_pkg::BIT_CNT_W'(bsp_pkg::GAIN_W - 1)) begin
                    // next product starts from its own operands
                    r_mcand  <= l_ld_mcand;
                    r_mplier <= l_ld_gain;
                end else begin
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            ST_RATE: begin
                r_rerr <= l_rerr;
                r_acc  <= '0;
            end
            ST_RINT: begin
                r_mcand  <= l_ld_mcand;
                r_mplier <= l_ld_gain;
            end
            ST_FIN: begin
                r_off <= l_off;
            end
            ST_OUT: begin
                if (l_out_wr) begin
                    r_duty <= l_duty;
                    r_soff <= r_off;
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid        = r_ov;
    assign o_res.servo_duty   = r_duty;
    assign o_res.steer_offset = r_soff;

endmodule
`default_nettype wire

### rtl/bsp_chk.sv
`default_nettype none
`include "balance_servo_pid_three_mode_assert.svh"
module bsp_chk #(
    parameter int MID_DUTY = bsp_pkg::MID_DUTY_DEF
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_in_enable,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [bsp_pkg::DUTY_W-1:0]         i_servo_duty,
    input wire logic signed [bsp_pkg::OFF_W-1:0]   i_steer_offset
);

    localparam bsp_pkg::t_off OFF_MIN = {1'b1, {(bsp_pkg::OFF_W-1){1'b0}}};
    localparam bsp_pkg::t_sum MID_S   = bsp_pkg::SUM_W'(MID_DUTY);
    localparam bsp_pkg::t_sum DMAX_S  = bsp_pkg::SUM_W'(bsp_pkg::DUTY_MAX);

    bsp_pkg::t_sum                                  l_sum;
    logic [bsp_pkg::DUTY_W-1:0]                     l_exp_duty;
    logic [bsp_pkg::DUTY_W+bsp_pkg::OFF_W-1:0]      l_res;

    assign l_sum = MID_S + bsp_pkg::t_sum'(i_steer_offset);
    assign l_res = {i_servo_duty, i_steer_offset};

    always_comb begin
        if (l_sum < 0) begin
            l_exp_duty = '0;
        end else if (l_sum > DMAX_S) begin
            l_exp_duty = bsp_pkg::DUTY_W'(DMAX_S);
        end else begin
            l_exp_duty = bsp_pkg::DUTY_W'(l_sum);
        end
    end

    // a waiting result keeps its value
    `BSP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(l_res))
    // an accepted enabled item makes the block busy
    `BSP_ASSERT_NXT(a_busy_after_item, i_in_valid && i_in_ready && i_in_enable, !i_in_ready)
    // a valid result's duty is mid duty plus the offset, saturated
    `BSP_ASSERT_IMP(a_duty_matches, i_out_valid, i_servo_duty == l_exp_duty)
    // offset clamp never reaches the most negative code
    `BSP_ASSERT_IMP(a_offset_range, i_out_valid, i_steer_offset != OFF_MIN)

endmodule

bind balance_servo_pid_three_mode bsp_chk #(.MID_DUTY(MID_DUTY)) u_bsp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_enable    (i_in.enable),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_servo_duty   (o_res.servo_duty),
    .i_steer_offset (o_res.steer_offset)
);
`default_nettype wire
